FILE: rtl/ptw_pkg.sv
package ptw_pkg;

	// Default number of 64-bit words in the table store.
	localparam int STORE_WORDS_DEF = 4096;

	localparam int PA_W     = 52;
	localparam int VA_W     = 48;
	localparam int WIDX_W   = 12;
	localparam int DATA_W   = 64;
	localparam int IDX_W    = 9;
	// A table word number: 40 frame bits of the table plus a 9-bit entry index.
	localparam int WORD_W   = PA_W - 12 + IDX_W;
	localparam int QUEUE_DEPTH = 2;

	localparam int PTE_PRESENT = 0;
	localparam int PTE_LARGE   = 7;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_UNMAPPED = 2'd1;
	localparam logic [1:0] STAT_OUTSIDE  = 2'd2;

	localparam logic [1:0] SIZE_4K = 2'd0;
	localparam logic [1:0] SIZE_2M = 2'd1;
	localparam logic [1:0] SIZE_1G = 2'd2;

	localparam logic [1:0] LEVEL_TOP = 2'd3;
	localparam logic [1:0] LEVEL_1G  = 2'd2;
	localparam logic [1:0] LEVEL_2M  = 2'd1;
	localparam logic [1:0] LEVEL_4K  = 2'd0;

	// Item kinds after classification by the front end.
	typedef enum logic [1:0] {
		CMD_WRITE     = 2'd0,
		CMD_WRITE_BAD = 2'd1,
		CMD_WALK      = 2'd2,
		CMD_WALK_BAD  = 2'd3
	} cmd_t;

	// One queued job. For a write, word holds the store index; for a walk it
	// holds the word number of the top-level entry.
	typedef struct packed {
		cmd_t                cmd;
		logic [WORD_W-1:0]   word;
		logic [DATA_W-1:0]   data;
		logic [VA_W-1:0]     va;
	} job_t;

	typedef struct packed {
		logic [1:0]      page_size;
		logic [PA_W-1:0] physical_address;
		logic [1:0]      status;
	} res_t;

	// Table index taken from the virtual address at a given level.
	function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
			input logic [1:0] lvl);
		logic [IDX_W-1:0] idx;
		case (lvl)
			LEVEL_TOP: idx = va[47:39];
			LEVEL_1G:  idx = va[38:30];
			LEVEL_2M:  idx = va[29:21];
			default:   idx = va[20:12];
		endcase
		return idx;
	endfunction

endpackage

FILE: rtl/ptw_ram.sv
module ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (re) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/ptw_queue.sv
module ptw_queue
	import ptw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  job_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output job_t pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/ptw_front.sv
module ptw_front
	import ptw_pkg::*;
#(
	parameter int STORE_WORDS = STORE_WORDS_DEF
) (
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [175:0] s_tdata,
	input  logic         s_tuser,
	input  logic         clear_busy,
	output logic         push_valid,
	input  logic         push_ready,
	output job_t         push_data
);

	localparam logic [WORD_W-1:0] LIMIT = WORD_W'(STORE_WORDS);

	logic [WIDX_W-1:0] word_index;
	logic [DATA_W-1:0] write_data;
	logic [PA_W-1:0]   root_address;
	logic [VA_W-1:0]   virtual_address;
	logic [WORD_W-1:0] write_word;
	logic [WORD_W-1:0] top_word;

	assign word_index      = s_tdata[11:0];
	assign write_data      = s_tdata[75:12];
	assign root_address    = s_tdata[127:76];
	assign virtual_address = s_tdata[175:128];

	// The root's low twelve bits are dropped: its frame sits next to the index.
	assign write_word = WORD_W'(word_index);
	assign top_word   = {root_address[PA_W-1:12], va_index(virtual_address, LEVEL_TOP)};

	always_comb begin
		push_data.data = write_data;
		push_data.va   = virtual_address;
		if (s_tuser) begin
			push_data.word = top_word;
			push_data.cmd  = (top_word >= LIMIT) ? CMD_WALK_BAD : CMD_WALK;
		end else begin
			push_data.word = write_word;
			push_data.cmd  = (write_word >= LIMIT) ? CMD_WRITE_BAD : CMD_WRITE;
		end
	end

	// Nothing is taken while the store is being cleared after reset.
	assign push_valid = s_tvalid && !clear_busy;
	assign s_tready   = push_ready && !clear_busy;

endmodule

FILE: rtl/ptw_back.sv
module ptw_back
	import ptw_pkg::*;
#(
	parameter int STORE_WORDS = STORE_WORDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	output logic clear_busy,
	input  logic pop_valid,
	output logic pop_ready,
	input  job_t pop_data,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = $clog2(STORE_WORDS);
	localparam logic [WORD_W-1:0] LIMIT = WORD_W'(STORE_WORDS);

	typedef enum logic [2:0] {
		S_CLEAR = 3'b001,
		S_IDLE  = 3'b010,
		S_LOOK  = 3'b100
	} state_t;

	state_t            state_q, state_d;
	logic [AW-1:0]     clr_addr_q;
	logic [1:0]        level_q, level_d;
	logic [VA_W-1:0]   va_q, va_d;
	logic              res_valid_q;
	res_t              res_q, res_d;
	logic              load_res;
	logic              out_free;

	logic              we, re;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [DATA_W-1:0] wr_data, entry;
	logic [WORD_W-1:0] next_word;
	logic              finish;

	ptw_ram #(
		.WIDTH(DATA_W),
		.DEPTH(STORE_WORDS)
	) u_store (
		.clk    (clk),
		.we     (we),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.re     (re),
		.rd_addr(rd_addr),
		.rd_data(entry)
	);

	assign out_free   = !res_valid_q || res_ready;
	assign clear_busy = (state_q == S_CLEAR);
	assign next_word  = {entry[PA_W-1:12], va_index(va_q, level_q - 2'd1)};

	always_comb begin
		state_d   = state_q;
		level_d   = level_q;
		va_d      = va_q;
		pop_ready = 1'b0;
		we        = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		re        = 1'b0;
		rd_addr   = '0;
		load_res  = 1'b0;
		res_d     = '0;
		finish    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				we      = 1'b1;
				wr_addr = clr_addr_q;
				if (clr_addr_q == AW'(STORE_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (pop_valid && out_free) begin
					pop_ready = 1'b1;
					case (pop_data.cmd)
						CMD_WRITE: begin
							we       = 1'b1;
							wr_addr  = pop_data.word[AW-1:0];
							wr_data  = pop_data.data;
							load_res = 1'b1;
						end
						CMD_WALK: begin
							re      = 1'b1;
							rd_addr = pop_data.word[AW-1:0];
							va_d    = pop_data.va;
							level_d = LEVEL_TOP;
							state_d = S_LOOK;
						end
						default: begin
							load_res     = 1'b1;
							res_d.status = STAT_OUTSIDE;
						end
					endcase
				end
			end
			S_LOOK: begin
				if (!entry[PTE_PRESENT]) begin
					finish       = 1'b1;
					res_d.status = STAT_UNMAPPED;
				end else if (level_q == LEVEL_1G && entry[PTE_LARGE]) begin
					finish                 = 1'b1;
					res_d.physical_address = {entry[PA_W-1:30], va_q[29:0]};
					res_d.page_size        = SIZE_1G;
				end else if (level_q == LEVEL_2M && entry[PTE_LARGE]) begin
					finish                 = 1'b1;
					res_d.physical_address = {entry[PA_W-1:21], va_q[20:0]};
					res_d.page_size        = SIZE_2M;
				end else if (level_q == LEVEL_4K) begin
					finish                 = 1'b1;
					res_d.physical_address = {entry[PA_W-1:12], va_q[11:0]};
					res_d.page_size        = SIZE_4K;
				end else if (next_word >= LIMIT) begin
					finish       = 1'b1;
					res_d.status = STAT_OUTSIDE;
				end else begin
					re      = 1'b1;
					rd_addr = next_word[AW-1:0];
					level_d = level_q - 2'd1;
				end
				// The read data register holds while a finished walk waits here.
				if (finish && out_free) begin
					load_res = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			level_q     <= LEVEL_TOP;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		va_q <= va_d;
		if (load_res) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

FILE: rtl/four_level_page_table_walker_core.sv
// Four-level page-table walker with its own store of 64-bit table words.
// Input channel (s_*): one transaction per item. s_tuser low writes
// write_data into the store word word_index; s_tuser high translates
// virtual_address through the four-level tables rooted at root_address.
// Output channel (m_*): one result transaction per input transaction, in
// order: status, physical_address and page_size.
// After reset the store is cleared to zero, one word per cycle, and
// s_tready stays low until the clearing is done.
// A front end classifies each item and places it in a two-entry queue; the
// back end executes jobs one at a time against the single-port-read store.
// The back end stores a write and loads its result as it pops it. A
// translation reads one table level after another (one to four, each a
// dependent registered store read, if its top entry lies in the store)
// and takes no new job until done; the result then sits in the output
// register. Sustained rate is one write per cycle while m_tready is high.
// When the receiver stalls the result stays in the output register, the
// back end holds its finished job, and the queue keeps accepting items
// until it is full.
module four_level_page_table_walker_core
	import ptw_pkg::*;
#(
	parameter int STORE_WORDS = STORE_WORDS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata, lowest bit up: word_index[11:0], write_data[75:12],
	// root_address[127:76], virtual_address[175:128]
	input  logic [175:0] s_tdata,
	// s_tuser: operation (0 write a table word, 1 translate)
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata, lowest bit up: status[1:0], physical_address[53:2],
	// page_size[55:54]
	output logic [55:0]  m_tdata
);

	logic clear_busy;
	logic push_valid, push_ready;
	job_t push_data;
	logic pop_valid, pop_ready;
	job_t pop_data;
	res_t res;

	ptw_front #(
		.STORE_WORDS(STORE_WORDS)
	) u_front (
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.clear_busy(clear_busy),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	ptw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	ptw_back #(
		.STORE_WORDS(STORE_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear_busy(clear_busy),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// The result struct is laid out status first in the low bits.
	assign m_tdata = res;

endmodule

FILE: bench/tb.sv
// Self-checking bench for the four-level page-table walker.
// An initial block queues the stimulus: a directed part first, then walks built
// from random table entries. A clocked driver offers the queued items and predicts
// every accepted one against a private copy of the table store. A clocked monitor
// checks each result transaction against the oldest prediction.
module tb
	import ptw_pkg::*;
();

	localparam int STORE_WORDS = STORE_WORDS_DEF;
	localparam int RANDOM_ITEMS = 1000;
	localparam int CYCLE_LIMIT = 600000;
	// Worst translation latency plus the output register, with margin.
	localparam int DRAIN_CYCLES = 40;
	// The long receiver hold-off starts after this many checked results.
	localparam int HOLD_AFTER = 300;
	localparam int HOLD_CYCLES = 400;

	// Operation codes carried on s_tuser.
	localparam logic OP_WRITE     = 1'b0;
	localparam logic OP_TRANSLATE = 1'b1;

	typedef struct {
		logic        operation;
		logic [11:0] word_index;
		logic [63:0] write_data;
		logic [51:0] root_address;
		logic [47:0] virtual_address;
	} walker_request_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [175:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [55:0]  m_tdata;

	four_level_page_table_walker_core #(
		.STORE_WORDS(STORE_WORDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to be offered, and the results owed by the block in order.
	walker_request_t walker_requests[$];
	res_t            predicted_results[$];

	// Private copy of the table store, cleared like the block's store after reset.
	logic [63:0] table_words [STORE_WORDS];

	bit failed = 1'b0;
	int results_checked = 0;
	int cycle_count = 0;

	initial begin
		for (int w = 0; w < STORE_WORDS; w++)
			table_words[w] = '0;
	end

	// Walks the tables in the private store exactly as the block must.
	// Each level reads one entry; a missing present bit ends the walk as not
	// mapped, a table word beyond the store ends it as outside, and the
	// page-size bit only counts at the 1G and 2M levels.
	function automatic res_t walk_tables(logic [51:0] root, logic [47:0] va);
		res_t        r;
		logic [51:0] tbl;
		logic [63:0] entry;
		logic [63:0] word;
		logic [8:0]  idx;
		bit          done;
		r = '0;
		done = 1'b0;
		// The low twelve bits of the root are not part of the table base.
		tbl = {root[51:12], 12'h000};
		for (int lvl = 3; lvl >= 0; lvl--) begin
			if (!done) begin
				idx = va[12 + 9 * lvl +: 9];
				word = 64'(tbl >> 3) + 64'(idx);
				if (word >= 64'(STORE_WORDS)) begin
					r.status = STAT_OUTSIDE;
					done = 1'b1;
				end else begin
					entry = table_words[word[11:0]];
					if (!entry[PTE_PRESENT]) begin
						r.status = STAT_UNMAPPED;
						done = 1'b1;
					end else if (lvl == int'(LEVEL_1G) && entry[PTE_LARGE]) begin
						r.physical_address = {entry[51:30], va[29:0]};
						r.page_size = SIZE_1G;
						done = 1'b1;
					end else if (lvl == int'(LEVEL_2M) && entry[PTE_LARGE]) begin
						r.physical_address = {entry[51:21], va[20:0]};
						r.page_size = SIZE_2M;
						done = 1'b1;
					end else begin
						// Top-level page-size bit and last-level PAT bit are ignored.
						tbl = {entry[51:12], 12'h000};
					end
				end
			end
		end
		if (!done) begin
			r.physical_address = {tbl[51:12], va[11:0]};
			r.page_size = SIZE_4K;
		end
		return r;
	endfunction

	function automatic logic [63:0] make_entry(logic [39:0] frame, logic [11:0] flags);
		return {12'h000, frame, flags};
	endfunction

	function automatic logic [47:0] make_va(logic [8:0] i3, logic [8:0] i2, logic [8:0] i1,
			logic [8:0] i0, logic [11:0] offset);
		return {i3, i2, i1, i0, offset};
	endfunction

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Next-table frame for a random walk: mostly a frame inside the store,
	// sometimes an arbitrary 40-bit frame that points outside it.
	function automatic logic [39:0] pick_table_frame();
		if ($urandom_range(0, 99) < 94)
			return 40'($urandom_range(0, STORE_WORDS / 512 - 1));
		return 40'(random_word());
	endfunction

	// Pause length between transactions: mostly none or short, a few long.
	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Unused fields of every request carry random bits, so that the block
	// is seen to ignore them.
	task automatic add_write(logic [11:0] word, logic [63:0] data);
		walker_request_t req;
		req.operation = OP_WRITE;
		req.word_index = word;
		req.write_data = data;
		req.root_address = 52'(random_word());
		req.virtual_address = 48'(random_word());
		walker_requests.push_back(req);
	endtask

	task automatic add_translate(logic [51:0] root, logic [47:0] va);
		walker_request_t req;
		req.operation = OP_TRANSLATE;
		req.word_index = 12'($urandom);
		req.write_data = random_word();
		req.root_address = root;
		req.virtual_address = va;
		walker_requests.push_back(req);
	endtask

	// Builds the tables for one random virtual address down to a random page
	// size, then translates it a few times with varied low bits. Entries are
	// mostly present and mostly point into the store, so most walks go deep.
	task automatic queue_random_walk();
		logic [47:0] va;
		logic [47:0] probe;
		logic [39:0] frame;
		logic [39:0] next_frame;
		logic [63:0] entry;
		logic [51:0] root;
		int          leaf_level;
		int          lvl;
		int          level_to_change;
		va = 48'(random_word());
		leaf_level = $urandom_range(0, 2);
		frame = 40'($urandom_range(0, STORE_WORDS / 512 - 1));
		root = {frame, ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'h000};
		lvl = 3;
		while (lvl >= leaf_level && frame < 40'(STORE_WORDS / 512)) begin
			next_frame = pick_table_frame();
			entry = random_word();
			entry[51:12] = next_frame;
			entry[PTE_PRESENT] = ($urandom_range(0, 99) < 94);
			if (lvl == int'(LEVEL_1G) || lvl == int'(LEVEL_2M))
				entry[PTE_LARGE] = (lvl == leaf_level);
			add_write({frame[2:0], va[12 + 9 * lvl +: 9]}, entry);
			frame = next_frame;
			lvl--;
		end
		repeat ($urandom_range(1, 3)) begin
			probe = va;
			probe[11:0] = 12'($urandom);
			if ($urandom_range(0, 1) == 0)
				probe[20:12] = 9'($urandom);
			if ($urandom_range(0, 3) == 0) begin
				level_to_change = $urandom_range(1, 3);
				probe[12 + 9 * level_to_change +: 9] = 9'($urandom);
			end
			add_translate(root, probe);
		end
	endtask

	// Driver: offers queued requests on the slave side and predicts each
	// accepted transaction in acceptance order.
	int  tx_pause = 0;
	bit  tx_steady = 1'b0;

	always @(posedge clk or negedge arst_n) begin : drive_requests
		walker_request_t req;
		logic [11:0]     widx;
		res_t            r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			tx_pause <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				r = '0;
				if (s_tuser == OP_WRITE) begin
					widx = s_tdata[11:0];
					if (int'(widx) < STORE_WORDS)
						table_words[widx] = s_tdata[75:12];
					else
						r.status = STAT_OUTSIDE;
				end else begin
					r = walk_tables(s_tdata[127:76], s_tdata[175:128]);
				end
				predicted_results.push_back(r);
			end
			// Now and then switch between back-to-back offering and random pauses.
			if ($urandom_range(0, 199) == 0)
				tx_steady = !tx_steady;
			if (!s_tvalid || s_tready) begin
				if (tx_pause != 0) begin
					s_tvalid <= 1'b0;
					tx_pause <= tx_pause - 1;
				end else if (walker_requests.size() != 0) begin
					req = walker_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= req.operation;
					s_tdata <= {req.virtual_address, req.root_address, req.write_data,
						req.word_index};
					tx_pause <= tx_steady ? 0 : pick_pause();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// One long receiver hold-off, counted here, once enough results have been
	// checked. The sender keeps offering meanwhile, so the block's queue fills
	// and s_tready has to drop.
	int hold_left = 0;
	bit hold_done = 1'b0;
	wire rx_hold = (hold_left != 0);

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && results_checked >= HOLD_AFTER) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end
	end

	// Monitor: drives m_tready with random stalls and checks every result
	// transaction field by field against the oldest prediction.
	int ready_wait = 0;
	bit rx_steady = 1'b0;

	always @(posedge clk or negedge arst_n) begin : check_results
		res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_wait <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (predicted_results.size() == 0) begin
					$error("result transaction with no prediction waiting: %h", m_tdata);
					failed = 1'b1;
				end else begin
					want = predicted_results.pop_front();
					if (m_tdata[1:0] !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, m_tdata[1:0]);
						failed = 1'b1;
					end
					if (m_tdata[53:2] !== want.physical_address) begin
						$error("physical_address: expected %h, actual %h",
							want.physical_address, m_tdata[53:2]);
						failed = 1'b1;
					end
					if (m_tdata[55:54] !== want.page_size) begin
						$error("page_size: expected %0d, actual %0d",
							want.page_size, m_tdata[55:54]);
						failed = 1'b1;
					end
				end
				results_checked <= results_checked + 1;
			end
			if ($urandom_range(0, 199) == 0)
				rx_steady = !rx_steady;
			if (rx_hold) begin
				m_tready <= 1'b0;
			end else if (ready_wait != 0) begin
				m_tready <= 1'b0;
				ready_wait <= ready_wait - 1;
			end else if (rx_steady || $urandom_range(0, 99) < 65) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				ready_wait <= pick_pause();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	localparam logic [51:0] ROOT1 = {40'd1, 12'h000};

	initial begin : run_test
		logic [47:0] va0;
		int          roll;
		int          expected_results;
		va0 = make_va(9'd5, 9'd6, 9'd7, 9'd8, 12'hABC);

		// Directed part. Tables: root in frame 1, then frames 2, 3 and 4.
		// Nothing is present right after reset.
		add_translate(ROOT1, va0);
		// A root far beyond the store, with an all-ones address.
		add_translate({52{1'b1}}, {48{1'b1}});
		// Top-level entry with its page-size bit and high bits set: both ignored.
		add_write({3'd1, 9'd5}, {12'hFFF, 40'd2, 12'h081});
		add_translate(ROOT1, va0);
		add_write({3'd2, 9'd6}, make_entry(40'd3, 12'h001));
		add_write({3'd3, 9'd7}, make_entry(40'd4, 12'h001));
		// Last-level entry with the PAT bit set and an all-ones frame.
		add_write({3'd4, 9'd8}, {12'hFFF, {40{1'b1}}, 12'h081});
		// Unaligned root: low twelve bits must be dropped.
		add_translate({40'd1, 12'hFFF}, va0);
		// All-ones third-level entry: 2M page, low entry bits kept out.
		add_write({3'd3, 9'd7}, {64{1'b1}});
		add_translate(ROOT1, va0);
		// All-ones second-level entry: 1G page.
		add_write({3'd2, 9'd6}, {64{1'b1}});
		add_translate(ROOT1, va0);
		// Second-level pointer to a table beyond the store.
		add_write({3'd2, 9'd6}, make_entry(40'd16, 12'h001));
		add_translate(ROOT1, va0);
		// Last-level table that was never filled: not mapped at the last level.
		add_write({3'd2, 9'd6}, make_entry(40'd3, 12'h001));
		add_write({3'd3, 9'd7}, make_entry(40'd5, 12'h001));
		add_translate(ROOT1, va0);
		// Last-level table just past the end of the store.
		add_write({3'd3, 9'd7}, make_entry(40'd8, 12'h001));
		add_translate(ROOT1, va0);
		// Highest store word, reached through the last top-level index.
		add_write(12'hFFF, make_entry(40'd0, 12'h001));
		add_translate({40'd7, 12'h000}, {48{1'b1}});
		// Root just past the store.
		add_translate({40'd8, 12'h000}, 48'h0);
		add_write(12'h000, 64'h0);

		// Random part: mostly well-formed walks, the rest random noise.
		while (walker_requests.size() < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 70)
				queue_random_walk();
			else if (roll < 85)
				add_translate(($urandom_range(0, 1) == 0) ? 52'(random_word()) :
					{40'($urandom_range(0, STORE_WORDS / 512 - 1)), 12'($urandom)},
					48'(random_word()));
			else
				add_write(12'($urandom), random_word());
		end
		// Every request owes exactly one result transaction.
		expected_results = walker_requests.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every owed result has been checked, then watch for extras.
		while (results_checked < expected_results)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failed || predicted_results.size() != 0) begin
			$display("simulation failed");
		end else begin
			$display("simulation ok");
		end
		$finish;
	end

endmodule
